FILE: rtl/core/bolist_pkg.sv
package bolist_pkg;

    // list geometry
    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);

    // beat field widths
    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;

    // common width for position against count compares
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

    // one result beat
    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [POS_W-1:0]        count_now;
        logic                    is_empty;
    } res_t;

endpackage

FILE: rtl/core/bolist_ram.sv
module bolist_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/bolist_ctrl.sv
module bolist_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bolist_pkg::OP_W-1:0]       in_operation,
    input  logic signed [bolist_pkg::VAL_W-1:0] in_item_value,
    input  logic [bolist_pkg::POS_W-1:0]      in_position,
    output logic                              res_valid,
    input  logic                              res_ready,
    output bolist_pkg::res_t                  res
);
    import bolist_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_PUT,
        ST_DEL,
        ST_SCAN,
        ST_RDW,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [CMP_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    wr_pend_reg;
    logic [IDX_W-1:0]        wa_reg;
    logic                    cmp_pend_reg;
    logic [CNT_W-1:0]        cmp_addr_reg;
    logic                    res_ok_reg;
    logic signed [VAL_W-1:0] res_rv_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    logic [CMP_W-1:0] in_pos_ext;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_dec;
    logic [CNT_W-1:0] idx_inc;
    logic             not_full;
    logic             hit;

    assign in_pos_ext = CMP_W'(in_position);
    assign count_ext  = CMP_W'(count_reg);
    assign idx_ext    = CMP_W'(idx_reg);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign not_full   = count_reg < CNT_W'(LIST_DEPTH);
    assign hit        = cmp_pend_reg && (val_reg == $signed(ram_rdata));

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res.ok         = res_ok_reg;
        res.read_value = res_rv_reg;
        res.count_now  = POS_W'(count_reg);
        res.is_empty   = (count_reg == '0);
    end

    // memory port control: shifts read one entry ahead of the write
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wa_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = idx_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                ram_re    = in_valid && (in_operation == OP_READ);
                ram_raddr = in_pos_ext[IDX_W-1:0];
            end
            ST_INS: begin
                ram_we    = wr_pend_reg;
                ram_re    = idx_ext > pos_reg;
                ram_raddr = idx_dec[IDX_W-1:0];
            end
            ST_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[IDX_W-1:0];
                ram_wdata = val_reg;
            end
            ST_DEL: begin
                ram_we    = wr_pend_reg;
                ram_re    = idx_inc < count_reg;
                ram_raddr = idx_inc[IDX_W-1:0];
            end
            ST_SCAN: begin
                ram_re = !hit && (idx_reg < count_reg);
            end
            default: begin
            end
        endcase
    end

    bolist_ram #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (VAL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            wr_pend_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        val_reg      <= in_item_value;
                        pos_reg      <= in_pos_ext;
                        wr_pend_reg  <= 1'b0;
                        cmp_pend_reg <= 1'b0;
                        res_ok_reg   <= 1'b0;
                        res_rv_reg   <= '0;
                        state_reg    <= ST_DONE;
                        case (in_operation)
                            OP_APPEND: begin
                                if (not_full) begin
                                    idx_reg   <= count_reg;
                                    pos_reg   <= count_ext;
                                    state_reg <= ST_INS;
                                end
                            end
                            OP_INSERT: begin
                                if (not_full && (in_pos_ext <= count_ext)) begin
                                    idx_reg   <= count_reg;
                                    state_reg <= ST_INS;
                                end
                            end
                            OP_DEL_VALUE: begin
                                idx_reg   <= '0;
                                state_reg <= ST_SCAN;
                            end
                            OP_DEL_AT: begin
                                if (in_pos_ext < count_ext) begin
                                    idx_reg   <= in_pos_ext[CNT_W-1:0];
                                    state_reg <= ST_DEL;
                                end
                            end
                            OP_READ: begin
                                if (in_pos_ext < count_ext) begin
                                    state_reg <= ST_RDW;
                                end
                            end
                            OP_CLEAR: begin
                                count_reg  <= '0;
                                res_ok_reg <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_INS: begin
                    wr_pend_reg <= idx_ext > pos_reg;
                    wa_reg      <= idx_reg[IDX_W-1:0];
                    if (idx_ext > pos_reg) begin
                        idx_reg <= idx_dec;
                    end else begin
                        state_reg <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    count_reg  <= count_reg + CNT_W'(1);
                    res_ok_reg <= 1'b1;
                    state_reg  <= ST_DONE;
                end
                ST_DEL: begin
                    if (idx_inc < count_reg) begin
                        wr_pend_reg <= 1'b1;
                        wa_reg      <= idx_reg[IDX_W-1:0];
                        idx_reg     <= idx_inc;
                    end else begin
                        wr_pend_reg <= 1'b0;
                        count_reg   <= count_reg - CNT_W'(1);
                        res_ok_reg  <= 1'b1;
                        state_reg   <= ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        idx_reg      <= cmp_addr_reg;
                        wr_pend_reg  <= 1'b0;
                        cmp_pend_reg <= 1'b0;
                        state_reg    <= ST_DEL;
                    end else if (idx_reg < count_reg) begin
                        cmp_pend_reg <= 1'b1;
                        cmp_addr_reg <= idx_reg;
                        idx_reg      <= idx_inc;
                    end else begin
                        cmp_pend_reg <= 1'b0;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_RDW: begin
                    res_ok_reg <= 1'b1;
                    res_rv_reg <= $signed(ram_rdata);
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // count stays within the list
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    // memory is written only by the shift and put steps
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_INS || state_reg == ST_PUT || state_reg == ST_DEL))
        else $error("memory write outside shift or put");

    // a put grows the list by exactly one
    a_put_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUT) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("put did not grow the count by one");

    // a stalled result holds
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !res_ready) |=>
        (state_reg == ST_DONE && $stable(res_ok_reg) && $stable(res_rv_reg)
         && $stable(count_reg)))
        else $error("pending result changed while stalled");

endmodule

FILE: rtl/core/bounded_ordered_list_engine.sv
// bounded ordered list engine
//
// keeps an ordered list of up to LIST_DEPTH signed 32-bit values in a
// synchronous memory, plus an entry count. one input beat carries an
// operation (append, insert at position, delete by value, delete at
// position, read, clear), a value and a position; each gives exactly one
// result beat with ok, read_value, entry_count_now and is_empty.
//
// both channels are valid/ready. input beats are taken one at a time; the
// memory shift loop moves one entry per cycle, so insert and delete at a
// position take longer the more entries lie behind it, and delete by value
// first scans the list for a match. the result is handed from the
// sequencer to an output register when that register is free; while the
// receiver stalls that register holds, and the next input beat is still
// taken and worked on until its own result is ready.
// reset empties the list (count to zero); memory contents are not cleared.
module bounded_ordered_list_engine (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [bolist_pkg::OP_W-1:0]          s_operation,
    input  logic signed [bolist_pkg::VAL_W-1:0]  s_item_value,
    input  logic [bolist_pkg::POS_W-1:0]         s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_ok,
    output logic signed [bolist_pkg::VAL_W-1:0]  m_read_value,
    output logic [bolist_pkg::POS_W-1:0]         m_entry_count_now,
    output logic                                 m_is_empty
);
    import bolist_pkg::*;

    // sequencer to output register handoff
    logic res_valid;
    logic res_ready;
    res_t res;

    // output register
    logic out_valid_reg;
    res_t out_reg;

    // slot is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_ready;

    bolist_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_operation  (s_operation),
        .in_item_value (s_item_value),
        .in_position   (s_position),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_ok              = out_reg.ok;
    assign m_read_value      = out_reg.read_value;
    assign m_entry_count_now = out_reg.count_now;
    assign m_is_empty        = out_reg.is_empty;

endmodule

FILE: dv/testbench.sv
module testbench;
    import bolist_pkg::*;

    // one input beat as the sender holds it
    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] val;
        logic [POS_W-1:0]        pos;
    } list_cmd_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [OP_W-1:0]         s_operation = '0;
    logic signed [VAL_W-1:0] s_item_value = '0;
    logic [POS_W-1:0]        s_position = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_ok;
    logic signed [VAL_W-1:0] m_read_value;
    logic [POS_W-1:0]        m_entry_count_now;
    logic                    m_is_empty;

    // beats still to be offered, and outcomes worked out but not yet seen
    list_cmd_t op_backlog[$];
    res_t      outcomes_due[$];

    // mirror of the list contents and fill level
    logic signed [VAL_W-1:0] list_mirror [LIST_DEPTH];
    int                      mirror_count = 0;

    int mismatch_count = 0;

    // sender burst shaping
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall shaping
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;
    int results_seen = 0;
    bit long_hold_done = 1'b0;

    bounded_ordered_list_engine u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_item_value      (s_item_value),
        .s_position        (s_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_read_value      (m_read_value),
        .m_entry_count_now (m_entry_count_now),
        .m_is_empty        (m_is_empty)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // apply one operation to the mirror and work out the result beat it gives
    function automatic res_t list_op_outcome(input logic [OP_W-1:0] op,
                                             input logic signed [VAL_W-1:0] val,
                                             input logic [POS_W-1:0] pos);
        res_t r;
        int   p;
        int   ins_at;
        int   drop_at;
        int   i;
        r = '0;
        p = int'(pos);
        ins_at = -1;
        drop_at = -1;
        case (op)
            OP_APPEND: begin
                if (mirror_count < LIST_DEPTH) ins_at = mirror_count;
            end
            OP_INSERT: begin
                // a position equal to the count lands at the tail
                if (mirror_count < LIST_DEPTH && p <= mirror_count) ins_at = p;
            end
            OP_DEL_VALUE: begin
                // first match only
                for (i = 0; i < mirror_count; i++) begin
                    if (drop_at < 0 && list_mirror[i] == val) drop_at = i;
                end
            end
            OP_DEL_AT: begin
                if (p < mirror_count) drop_at = p;
            end
            OP_READ: begin
                if (p < mirror_count) begin
                    r.ok = 1'b1;
                    r.read_value = list_mirror[p];
                end
            end
            OP_CLEAR: begin
                mirror_count = 0;
                r.ok = 1'b1;
            end
            default: begin
                // undefined codes leave the list alone and fail
            end
        endcase
        if (ins_at >= 0) begin
            for (i = mirror_count; i > ins_at; i--) list_mirror[i] = list_mirror[i - 1];
            list_mirror[ins_at] = val;
            mirror_count++;
            r.ok = 1'b1;
        end
        if (drop_at >= 0) begin
            for (i = drop_at; i + 1 < mirror_count; i++) list_mirror[i] = list_mirror[i + 1];
            mirror_count--;
            r.ok = 1'b1;
        end
        r.count_now = POS_W'(mirror_count);
        r.is_empty = (mirror_count == 0);
        return r;
    endfunction

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        list_cmd_t c;
        c.op = op;
        c.val = val;
        c.pos = pos;
        op_backlog.push_back(c);
    endtask

    // driver: works out each accepted beat, then offers the next one from
    // the backlog in bursts with idle gaps between them
    always @(posedge aclk) begin
        list_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                outcomes_due.push_back(list_op_outcome(s_operation, s_item_value, s_position));
            end
            // the slot is free once the held beat is taken or nothing is held
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    c = op_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= c.op;
                    s_item_value <= c.val;
                    s_position <= c.pos;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // now and then a long run with no gaps at all
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver: checks each result beat against the oldest
    // outcome due, then picks the next ready level from its own pattern
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: result beat with nothing due, expected none, got ok=%0b rd=%0h cnt=%0d",
                             $time, m_ok, m_read_value, m_entry_count_now);
                    mismatch_count++;
                end else begin
                    want = outcomes_due.pop_front();
                    flag_field("ok", 32'(want.ok), 32'(m_ok));
                    flag_field("read_value", want.read_value, m_read_value);
                    flag_field("entry_count_now", 32'(want.count_now), 32'(m_entry_count_now));
                    flag_field("is_empty", 32'(want.is_empty), 32'(m_is_empty));
                end
                results_seen++;
            end
            rx_cycle++;
            if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && results_seen == 250) begin
                // long hold-off so the output register and input side back up
                long_hold_done = 1'b1;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (rx_cycle % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial begin
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] val;
        logic [POS_W-1:0]        pos;
        int n;
        int roll;
        int phase_left;
        bit grow;

        // directed opening: empty list, extremes, ends of the list, bad codes
        queue_cmd(OP_READ, 0, 0);                   // read on empty
        queue_cmd(OP_DEL_AT, 0, 0);                 // delete at on empty
        queue_cmd(OP_DEL_VALUE, 0, 0);              // value search on empty
        queue_cmd(OP_APPEND, 32'sh8000_0000, 0);
        queue_cmd(OP_APPEND, 32'sh7fff_ffff, 0);
        queue_cmd(OP_INSERT, 0, 0);                 // insert at head
        queue_cmd(OP_INSERT, -1, 3);                // position equal to count
        queue_cmd(OP_INSERT, 9, 5);                 // past the tail
        queue_cmd(OP_APPEND, 7, 0);
        queue_cmd(OP_APPEND, 7, 0);
        queue_cmd(OP_READ, 0, 5);                   // last entry
        queue_cmd(OP_READ, 0, 6);                   // one past the last entry
        queue_cmd(OP_READ, 0, 31);
        queue_cmd(OP_DEL_VALUE, 7, 0);              // duplicate, first one only
        queue_cmd(OP_DEL_VALUE, 12345, 0);          // no match
        queue_cmd(OP_DEL_AT, 0, 0);                 // head only
        queue_cmd(OP_DEL_AT, 0, 2);
        queue_cmd(OP_DEL_AT, 0, 2);                 // tail
        queue_cmd(OP_READ, 0, 0);
        queue_cmd(3'd6, -1, 31);                    // undefined codes
        queue_cmd(3'd7, 0, 16);
        queue_cmd(OP_CLEAR, 0, 0);
        queue_cmd(OP_CLEAR, 0, 0);                  // clear when already empty
        queue_cmd(OP_INSERT, 32'sh8000_0000, 0);
        queue_cmd(OP_DEL_VALUE, 32'sh8000_0000, 0);

        // random part: alternating fill and drain phases so the list runs
        // between empty and full, with a small value pool for search hits
        grow = 1'b0;
        phase_left = 0;
        for (n = 0; n < 850; n++) begin
            if (phase_left == 0) begin
                grow = !grow;
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 2)       op = OP_CLEAR;
            else if (roll < 4)  op = OP_W'($urandom_range(6, 7));
            else if (roll < 14) op = OP_READ;
            else if (grow) begin
                if (roll < 55)      op = OP_APPEND;
                else if (roll < 90) op = OP_INSERT;
                else if (roll < 95) op = OP_DEL_AT;
                else                op = OP_DEL_VALUE;
            end else begin
                if (roll < 50)      op = OP_DEL_VALUE;
                else if (roll < 88) op = OP_DEL_AT;
                else if (roll < 94) op = OP_APPEND;
                else                op = OP_INSERT;
            end
            roll = $urandom_range(0, 9);
            if (roll < 5)       val = $urandom_range(0, 7) - 4;
            else if (roll == 5) val = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            else                val = $urandom;
            roll = $urandom_range(0, 19);
            if (roll == 0)     pos = POS_W'($urandom_range(17, 31));
            else if (roll < 7) pos = POS_W'($urandom_range(0, 2));
            else               pos = POS_W'($urandom_range(0, 16));
            queue_cmd(op, val, pos);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (op_backlog.size() != 0 || s_valid) @(posedge aclk);
        while (outcomes_due.size() != 0) @(posedge aclk);
        // longest shift is well under this; catches any stray extra beat
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bolist_pkg.sv
rtl/core/bolist_ram.sv
rtl/core/bolist_ctrl.sv
rtl/core/bounded_ordered_list_engine.sv
dv/testbench.sv
